// File: rtl/core/complex_magnitude_block_rms_unit_assert.svh
// assertion macros shared by the complex magnitude rms block
`ifndef COMPLEX_MAGNITUDE_BLOCK_RMS_UNIT_ASSERT_SVH
`define COMPLEX_MAGNITUDE_BLOCK_RMS_UNIT_ASSERT_SVH

// same-cycle implication
`define CMBR_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("cmbr same-cycle check failed");

// next-cycle implication
`define CMBR_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("cmbr next-cycle check failed");

`endif

// File: rtl/core/cmbr_pkg.sv
// types and constants of the complex magnitude rms block
package cmbr_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int MAX_BLOCK = 16;
   localparam int SUM_W     = 25;
   localparam int TILE_AW   = $clog2(MAX_WIDTH);
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   localparam int DIV_NUM_W = SUM_W;
   localparam int DIV_DEN_W = 9;
   localparam int SQRT_IN_W = 32;
   localparam int SQRT_OUT_W = SQRT_IN_W / 2;

   localparam logic [4:0]  BLOCK_SIZE_RESET  = 5'd8;
   localparam logic [12:0] LINE_WIDTH_RESET  = 13'd4096;
   localparam logic [9:0]  BORDER_SKIP_RESET = 10'd0;
   localparam logic [23:0] GAIN_RESET        = 24'd65536;

   typedef enum logic [1:0] {
      REG_BLOCK_SIZE  = 2'd0,
      REG_LINE_WIDTH  = 2'd1,
      REG_BORDER_SKIP = 2'd2,
      REG_GAIN        = 2'd3
   } reg_index_type;

   typedef enum logic [4:0] {
      S_IDLE, S_POS, S_DIV1, S_TMUL, S_TCHK, S_RE, S_IM, S_SQRT1,
      S_GAIN, S_CLIP, S_SQP, S_SUM, S_DIVS, S_DIV2, S_SQRT2, S_OUT, S_ADV
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

// File: rtl/core/cmbr_ram.sv
// line store with one write port and one registered read port
module cmbr_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 25
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/core/cmbr_div.sv
// restoring divider, one quotient bit per cycle
module cmbr_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [cmbr_pkg::DIV_NUM_W-1:0]      num,
   input  logic [cmbr_pkg::DIV_DEN_W-1:0]      den,
   output logic [cmbr_pkg::DIV_NUM_W-1:0]      quot,
   output logic [cmbr_pkg::DIV_DEN_W-1:0]      rem,
   output cmbr_pkg::unit_stat_type              stat
);
   import cmbr_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DIV_DEN_W:0]   shifted;
   logic                 qbit;

   always_comb begin
      shifted = {rem_ff, num_ff[DIV_NUM_W-1]};
      qbit    = (shifted >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-2:0], qbit};
         rem_in = qbit ? DIV_DEN_W'(shifted - {1'b0, den_ff}) : shifted[DIV_DEN_W-1:0];
         cnt_in = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quot = num_ff;
   assign rem  = rem_ff;
   assign stat = '{busy: busy_ff, done: done_ff};
endmodule

// File: rtl/core/cmbr_sqrt.sv
// integer square root, one root bit per cycle
module cmbr_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [cmbr_pkg::SQRT_IN_W-1:0]    radicand,
   output logic [cmbr_pkg::SQRT_OUT_W-1:0]   root,
   output cmbr_pkg::unit_stat_type           stat
);
   import cmbr_pkg::*;

   localparam int CNT_W = $clog2(SQRT_OUT_W);
   localparam int REM_W = SQRT_OUT_W + 4;

   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SQRT_IN_W-1:0]  x_ff, x_in;
   logic [REM_W-1:0]      rem_ff, rem_in, shifted, trial;
   logic [SQRT_OUT_W-1:0] root_ff, root_in;
   logic                  take;

   always_comb begin
      shifted = {rem_ff[REM_W-3:0], x_ff[SQRT_IN_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      take    = (shifted >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         x_in    = {x_ff[SQRT_IN_W-3:0], 2'b00};
         rem_in  = take ? REM_W'(shifted - trial) : shifted;
         root_in = {root_ff[SQRT_OUT_W-2:0], take};
         cnt_in  = CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == CNT_W'(SQRT_OUT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign stat = '{busy: busy_ff, done: done_ff};
endmodule

// File: rtl/core/complex_magnitude_block_rms_unit.sv
// Complex magnitude tile-rms downsampler. A request is taken only while the sequencer is idle.
// A sample dropped in the border leaves after the column check, a sample past the last whole
// tile after the tile check, and a sample that closes a tile also waits for the output
// register while it is full. The shared restoring divider (run once for the column split and
// once for the tile mean) and the shared bit-serial square root (run once for the magnitude
// and once for the tile rms) do the iterative steps, with one shared 24x24 multiplier in
// between. A finished pixel waits in an output register, so the next request is taken while
// it is still unread. The tile sums live in a 4096x25 line store with undefined content
// after reset and no clearing pass.
`include "complex_magnitude_block_rms_unit_assert.svh"

module complex_magnitude_block_rms_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // real_part[15:0], imag_part[31:16]
   input  logic [0:0]  req_tuser,   // first_of_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // pixel
   output logic        rsp_tlast,   // end_of_row
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import cmbr_pkg::*;

   // configuration
   logic [4:0]  block_size_ff;
   logic [12:0] line_width_ff;
   logic [9:0]  border_skip_ff;
   logic [23:0] gain_ff;
   logic        csr_wr;
   reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= BLOCK_SIZE_RESET;
         line_width_ff  <= LINE_WIDTH_RESET;
         border_skip_ff <= BORDER_SKIP_RESET;
         gain_ff        <= GAIN_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_BLOCK_SIZE:  block_size_ff  <= csr_pwdata[4:0];
            REG_LINE_WIDTH:  line_width_ff  <= csr_pwdata[12:0];
            REG_BORDER_SKIP: border_skip_ff <= csr_pwdata[9:0];
            REG_GAIN:        gain_ff        <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_BLOCK_SIZE:  csr_prdata = {27'd0, block_size_ff};
         REG_LINE_WIDTH:  csr_prdata = {19'd0, line_width_ff};
         REG_BORDER_SKIP: csr_prdata = {22'd0, border_skip_ff};
         REG_GAIN:        csr_prdata = {8'd0, gain_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // effective settings
   logic [4:0]  bs_eff;
   logic [12:0] lw_eff;
   logic [13:0] row_len;

   always_comb begin
      priority if (block_size_ff == 5'd0) begin
         bs_eff = 5'd1;
      end else if (block_size_ff > 5'(MAX_BLOCK)) begin
         bs_eff = 5'(MAX_BLOCK);
      end else begin
         bs_eff = block_size_ff;
      end
      lw_eff  = (line_width_ff > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : line_width_ff;
      row_len = 14'(border_skip_ff) + 14'(lw_eff);
   end

   // sequencer state and datapath registers
   state_type state_ff, state_in;
   logic [12:0] col_ff, col_in;
   logic [3:0]  row_ff, row_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_pixel_ff;
   logic        rsp_last_ff;

   logic [15:0] re_ff, im_ff;
   logic [12:0] tile_ff;
   logic [3:0]  cit_ff;
   logic        last_tile_ff;
   logic [31:0] acc_ff;
   logic [15:0] mag_ff;
   logic [7:0]  px_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [47:0] mul_p_ff;

   // datapath control
   logic        req_take, out_load;
   logic        lat_tile, lat_chk, lat_acc, lat_mag, lat_px, lat_sum;
   logic [23:0] mul_a, mul_b;
   logic        div_start, sqrt_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [SQRT_IN_W-1:0] sqrt_in;
   logic        ram_rd, ram_wr;

   logic [DIV_NUM_W-1:0] div_quot;
   logic [DIV_DEN_W-1:0] div_rem;
   logic [SQRT_OUT_W-1:0] sqrt_root;
   unit_stat_type div_stat, sqrt_stat;
   logic [SUM_W-1:0] ram_q;

   logic [15:0] re_abs, im_abs;
   logic [13:0] tile_end;
   logic        tile_ok;
   logic [SUM_W:0] sum_wide;
   logic [SUM_W-1:0] sum_new;
   logic        emit;
   logic [7:0]  root_clip;

   assign re_abs = re_ff[15] ? 16'(~re_ff + 16'd1) : re_ff;
   assign im_abs = im_ff[15] ? 16'(~im_ff + 16'd1) : im_ff;

   // mul_p_ff holds (tile + 1) * block_size during the tile check
   assign tile_end = mul_p_ff[13:0];
   assign tile_ok  = (tile_end <= 14'(lw_eff));

   always_comb begin
      sum_wide = {1'b0, ram_q} + (SUM_W + 1)'(mul_p_ff[15:0]);
      if (row_ff == 4'd0 && cit_ff == 4'd0) begin
         sum_new = SUM_W'(mul_p_ff[15:0]);
      end else if (sum_wide[SUM_W]) begin
         sum_new = SUM_MAX;
      end else begin
         sum_new = sum_wide[SUM_W-1:0];
      end
      emit = (5'(row_ff) >= 5'(bs_eff - 5'd1)) && (5'(cit_ff) == 5'(bs_eff - 5'd1));
      root_clip = (|sqrt_root[15:8]) ? 8'd255 : sqrt_root[7:0];
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      req_take     = 1'b0;
      out_load     = 1'b0;
      lat_tile     = 1'b0;
      lat_chk      = 1'b0;
      lat_acc      = 1'b0;
      lat_mag      = 1'b0;
      lat_px       = 1'b0;
      lat_sum      = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      sqrt_start   = 1'b0;
      sqrt_in      = '0;
      ram_rd       = 1'b0;
      ram_wr       = 1'b0;
      req_tready   = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               req_take = 1'b1;
               if (req_tuser[0]) begin
                  col_in = '0;
                  row_in = '0;
               end
               state_in = S_POS;
            end
         end
         S_POS: begin
            if (col_ff >= 13'(border_skip_ff)) begin
               div_start = 1'b1;
               div_num   = DIV_NUM_W'(col_ff - 13'(border_skip_ff));
               div_den   = DIV_DEN_W'(bs_eff);
               state_in  = S_DIV1;
            end else begin
               state_in = S_ADV;
            end
         end
         S_DIV1: begin
            if (div_stat.done) begin
               lat_tile = 1'b1;
               state_in = S_TMUL;
            end
         end
         S_TMUL: begin
            mul_a    = 24'(tile_ff) + 24'd1;
            mul_b    = 24'(bs_eff);
            state_in = S_TCHK;
         end
         S_TCHK: begin
            lat_chk  = 1'b1;
            mul_a    = 24'(re_abs);
            mul_b    = 24'(re_abs);
            ram_rd   = tile_ok;
            state_in = tile_ok ? S_RE : S_ADV;
         end
         S_RE: begin
            lat_acc  = 1'b1;
            mul_a    = 24'(im_abs);
            mul_b    = 24'(im_abs);
            state_in = S_IM;
         end
         S_IM: begin
            sqrt_start = 1'b1;
            sqrt_in    = acc_ff + mul_p_ff[31:0];
            state_in   = S_SQRT1;
         end
         S_SQRT1: begin
            if (sqrt_stat.done) begin
               lat_mag  = 1'b1;
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            mul_a    = 24'(mag_ff);
            mul_b    = gain_ff;
            state_in = S_CLIP;
         end
         S_CLIP: begin
            lat_px   = 1'b1;
            state_in = S_SQP;
         end
         S_SQP: begin
            mul_a    = 24'(px_ff);
            mul_b    = 24'(px_ff);
            state_in = S_SUM;
         end
         S_SUM: begin
            lat_sum  = 1'b1;
            ram_wr   = 1'b1;
            mul_a    = 24'(bs_eff);
            mul_b    = 24'(bs_eff);
            state_in = emit ? S_DIVS : S_ADV;
         end
         S_DIVS: begin
            div_start = 1'b1;
            div_num   = sum_ff;
            div_den   = mul_p_ff[DIV_DEN_W-1:0];
            state_in  = S_DIV2;
         end
         S_DIV2: begin
            if (div_stat.done) begin
               sqrt_start = 1'b1;
               sqrt_in    = SQRT_IN_W'(div_quot);
               state_in   = S_SQRT2;
            end
         end
         S_SQRT2: begin
            if (sqrt_stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold the pixel until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_ADV;
            end
         end
         S_ADV: begin
            if (14'(col_ff) + 14'd1 >= row_len) begin
               col_in = '0;
               row_in = (5'(row_ff) >= 5'(bs_eff - 5'd1)) ? 4'd0 : 4'(row_ff + 4'd1);
            end else begin
               col_in = 13'(col_ff + 13'd1);
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_a * mul_b;
      if (req_take) begin
         re_ff <= req_tdata[15:0];
         im_ff <= req_tdata[31:16];
      end
      if (lat_tile) begin
         tile_ff <= div_quot[12:0];
         cit_ff  <= div_rem[3:0];
      end
      if (lat_chk) begin
         last_tile_ff <= (tile_end + 14'(bs_eff) > 14'(lw_eff));
      end
      if (lat_acc) begin
         acc_ff <= mul_p_ff[31:0];
      end
      if (lat_mag) begin
         mag_ff <= sqrt_root;
      end
      if (lat_px) begin
         px_ff <= (|mul_p_ff[39:24]) ? 8'd255 : mul_p_ff[23:16];
      end
      if (lat_sum) begin
         sum_ff <= sum_new;
      end
      if (out_load) begin
         rsp_pixel_ff <= root_clip;
         rsp_last_ff  <= last_tile_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tlast  = rsp_last_ff;

   cmbr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_quot),
      .rem   (div_rem),
      .stat  (div_stat)
   );

   cmbr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_in),
      .root     (sqrt_root),
      .stat     (sqrt_stat)
   );

   cmbr_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (SUM_W)
   ) u_sums (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (tile_ff[TILE_AW-1:0]),
      .wr_data (sum_new),
      .rd_en   (ram_rd),
      .rd_addr (tile_ff[TILE_AW-1:0]),
      .rd_data (ram_q)
   );

   `CMBR_ASSERT_NOW(a_out_free, clock, reset, out_load, !rsp_valid_ff || rsp_tready)
   `CMBR_ASSERT_NOW(a_div_idle, clock, reset, div_start, !div_stat.busy)
   `CMBR_ASSERT_NOW(a_sqrt_idle, clock, reset, sqrt_start, !sqrt_stat.busy)
   `CMBR_ASSERT_NEXT(a_take_pos, clock, reset, req_take, state_ff == S_POS)
endmodule

// File: verif/complex_magnitude_block_rms_unit_test.sv
// testbench for the complex magnitude tile-rms downsampler: directed table, an extremes frame, then random frames
`timescale 1ns / 100ps

module complex_magnitude_block_rms_unit_test;
   import cmbr_pkg::*;

   typedef struct {
      logic signed [15:0] re;
      logic signed [15:0] im;
      logic               sof;
      logic               known;   // expected pixel typed in
      logic [7:0]         pixel;
      logic               eor;
   } stim_row_type;

   typedef struct {
      logic [7:0] pixel;
      logic       eor;
   } tile_out_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   complex_magnitude_block_rms_unit dut (.*);

   // predictor copy of the block state
   logic [24:0] tile_sums [MAX_WIDTH];
   logic [12:0] col_pos;
   logic [3:0]  band_row;
   logic [4:0]  cfg_block;
   logic [12:0] cfg_width;
   logic [9:0]  cfg_skip;
   logic [23:0] cfg_gain;

   tile_out_type pixel_queue[$];
   int errors;
   int requests_sent;
   int pixels_seen;
   int phases_run;
   bit long_hold;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [15:0] isqrt32(logic [31:0] v);
      logic [31:0] root;
      logic [31:0] bitv;
      root = 0;
      bitv = 32'h4000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[15:0];
   endfunction

   // advances the state for one sample; returns 1 when a tile closes
   function automatic bit predict_tile(logic signed [15:0] re, logic signed [15:0] im,
                                       logic sof, output tile_out_type res);
      int unsigned bs, lw, rowlen, ntiles, c, tile, cit, mag2, px, sum;
      longint unsigned scaled;
      bit hit;
      hit = 0;
      res = '{8'd0, 1'b0};
      if (sof) begin
         col_pos = 0;
         band_row = 0;
      end
      bs = cfg_block;
      if (bs == 0) bs = 1;
      if (bs > MAX_BLOCK) bs = MAX_BLOCK;
      lw = cfg_width;
      if (lw > MAX_WIDTH) lw = MAX_WIDTH;
      rowlen = cfg_skip + lw;
      ntiles = lw / bs;
      if (col_pos >= cfg_skip) begin
         c = col_pos - cfg_skip;
         tile = c / bs;
         cit = c % bs;
         if (tile < ntiles) begin
            mag2 = int'(re) * int'(re) + int'(im) * int'(im);
            scaled = (longint'(isqrt32(mag2)) * cfg_gain) >> 16;
            px = scaled > 255 ? 255 : int'(scaled);
            if (band_row == 0 && cit == 0) sum = px * px;
            else begin
               sum = tile_sums[tile] + px * px;
               if (sum > SUM_MAX) sum = SUM_MAX;
            end
            tile_sums[tile] = sum;
            if (band_row >= bs - 1 && cit == bs - 1) begin
               mag2 = isqrt32(sum / (bs * bs));
               res.pixel = mag2 > 255 ? 8'd255 : mag2[7:0];
               res.eor = (tile == ntiles - 1);
               hit = 1;
            end
         end
      end
      if (col_pos + 1 >= rowlen) begin
         col_pos = 0;
         band_row = (band_row >= bs - 1) ? 0 : band_row + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return hit;
   endfunction

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_BLOCK_SIZE:  cfg_block = value[4:0];
         REG_LINE_WIDTH:  cfg_width = value[12:0];
         REG_BORDER_SKIP: cfg_skip = value[9:0];
         REG_GAIN:        cfg_gain = value[23:0];
      endcase
   endtask

   task automatic set_geometry(int bs, int lw, int skip, int g);
      csr_write(REG_BLOCK_SIZE, bs);
      csr_write(REG_LINE_WIDTH, lw);
      csr_write(REG_BORDER_SKIP, skip);
      csr_write(REG_GAIN, g);
      phases_run++;
   endtask

   // the sender: bursts with random gaps
   int burst_left;
   task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im, logic sof,
                              bit known, tile_out_type typed);
      tile_out_type res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {im, re};
      req_tuser <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // table rows with a typed-in result are checked against that result
      if (predict_tile(re, im, sof, res)) pixel_queue.push_back(known ? typed : res);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pixel_queue.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      if (guard >= 200000) begin
         $display("TB_ERROR");
         $finish;
      end
      repeat (120) @(posedge clock);
   endtask

   // receiver: random stall pattern, plus a long hold whenever one is requested
   initial begin
      int hold;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            for (hold = 0; hold < 3000; hold++) @(negedge clock);
            long_hold = 0;
         end
         rsp_tready <= ($urandom_range(0, 9) < 6) || ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      tile_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         pixels_seen++;
         if (pixel_queue.size() == 0) begin
            $error("unexpected pixel %0d", rsp_tdata);
            errors++;
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_tdata !== want.pixel) begin
               $error("pixel expected %0d actual %0d", want.pixel, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== want.eor) begin
               $error("end_of_row expected %0d actual %0d", want.eor, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // block 1, width 2: every sample closes a tile, so pixels read straight off
   stim_row_type directed[10] = '{
      '{16'sd0, 16'sd0, 1'b1, 1'b1, 8'd0, 1'b0},
      '{16'sd3, 16'sd4, 1'b0, 1'b1, 8'd5, 1'b1},
      '{16'sd32767, 16'sd32767, 1'b0, 1'b1, 8'd255, 1'b0},
      '{-16'sd32768, -16'sd32768, 1'b0, 1'b1, 8'd255, 1'b1},
      '{-16'sd32768, 16'sd0, 1'b1, 1'b1, 8'd255, 1'b0},
      '{16'sd255, 16'sd0, 1'b0, 1'b1, 8'd255, 1'b1},
      '{-16'sd12, 16'sd5, 1'b0, 1'b1, 8'd13, 1'b0},
      '{16'sd100, -16'sd1, 1'b0, 1'b0, 8'd0, 1'b0},
      '{16'sh5555, -16'sh5556, 1'b0, 1'b0, 8'd0, 1'b0},
      '{-16'sh5556, 16'sh5555, 1'b0, 1'b0, 8'd0, 1'b0}
   };

   task automatic random_frame(int rows);
      int lw, i;
      tile_out_type none;
      none = '{8'd0, 1'b0};
      lw = cfg_skip + (cfg_width > MAX_WIDTH ? MAX_WIDTH : cfg_width);
      for (i = 0; i < rows * lw; i++) begin
         if ($urandom_range(0, 1)) send_sample($urandom, $urandom, i == 0, 0, none);
         else send_sample($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                          i == 0, 0, none);
      end
   endtask

   initial begin
      tile_out_type typed;
      int i, bs;
      errors = 0;
      requests_sent = 0;
      pixels_seen = 0;
      phases_run = 0;
      long_hold = 0;
      burst_left = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      col_pos = 0;
      band_row = 0;
      cfg_block = BLOCK_SIZE_RESET;
      cfg_width = LINE_WIDTH_RESET;
      cfg_skip = BORDER_SKIP_RESET;
      cfg_gain = GAIN_RESET;
      for (i = 0; i < MAX_WIDTH; i++) tile_sums[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_geometry(1, 2, 0, 24'h10000);
      foreach (directed[k]) begin
         typed = '{directed[k].pixel, directed[k].eor};
         send_sample(directed[k].re, directed[k].im, directed[k].sof, directed[k].known, typed);
      end
      drain();

      // extremes: largest tile with a border, full gain clipping most magnitudes
      set_geometry(16, 32, 8, 24'hFFFFFF);
      for (i = 0; i < 16 * 40; i++) begin
         typed = '{8'd0, 1'b0};
         if (i >= 16 * 40 - 20 || (i % 40) >= 8)
            send_sample($urandom, $urandom, i == 0, 0, typed);
         else begin
            // cheap path through the skipped border
            send_sample(16'sd1, 16'sd1, i == 0, 0, typed);
         end
         if (i == 16 * 40 - 40) long_hold = 1;
      end
      drain();

      // random geometries, small widths, ragged tails beyond the last tile
      while (requests_sent < 1380) begin
         bs = $urandom_range(1, 6);
         set_geometry(bs, bs * $urandom_range(1, 4) + $urandom_range(0, bs - 1),
                      $urandom_range(0, 3), $urandom_range(0, 3) == 0 ?
                      $urandom : $urandom_range(0, 24'h3FFFF));
         random_frame(bs * $urandom_range(1, 3));
         if ($urandom_range(0, 5) == 0) long_hold = 1;
         drain();
      end
      // width zero leaves no tiles
      set_geometry(0, 0, 3, 24'h10000);
      random_frame(2);
      drain();
      set_geometry(BLOCK_SIZE_RESET, LINE_WIDTH_RESET, BORDER_SKIP_RESET, GAIN_RESET);

      $display("covered %0d requests, %0d pixels, %0d register settings",
               requests_sent, pixels_seen, phases_run);
      if (errors == 0 && pixel_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
